// ----- rtl/core/wqi_pkg.sv -----
// Shared types and constants for the water quality index scorer.
// Holds the sensor lane numbering, register indexes, result codes and the
// fixed reciprocals used for the constant divisions. Depends on nothing.
package wqi_pkg;

   typedef logic [13:0] score_type;
   typedef logic [9:0]  weight_type;

   // Sensor lanes: scores and weights are kept in arrays in this order.
   localparam int SENSOR_PH          = 0;
   localparam int SENSOR_COND        = 1;
   localparam int SENSOR_GAS         = 2;
   localparam int SENSOR_WATER_TEMP  = 3;
   localparam int SENSOR_HUMIDITY    = 4;
   localparam int NUM_SENSORS        = 5;

   // Configuration register indexes.
   localparam logic [2:0] CSR_WEIGHT_PH         = 3'd0;
   localparam logic [2:0] CSR_WEIGHT_COND       = 3'd1;
   localparam logic [2:0] CSR_WEIGHT_GAS        = 3'd2;
   localparam logic [2:0] CSR_WEIGHT_WATER_TEMP = 3'd3;
   localparam logic [2:0] CSR_WEIGHT_HUMIDITY   = 3'd4;

   localparam weight_type WEIGHT_RESET = 10'd200;
   localparam score_type  SCORE_MAX    = 14'd10000;
   localparam score_type  GOOD_LIMIT   = 14'd7000;
   localparam score_type  WARN_LIMIT   = 14'd4000;

   // floor(x / 10) = (x * 52429) >> 19, exact for x below 2**18.
   localparam logic [16:0] DIV10_RECIP = 17'd52429;
   localparam int          DIV10_SHIFT = 19;

   // floor(s / 1000) = (s * 68719477) >> 36, exact for s below 2**26.
   localparam logic [26:0] DIV1000_RECIP = 27'd68719477;
   localparam int          DIV1000_SHIFT = 36;

   typedef enum logic [1:0] {
      LEVEL_GOOD     = 2'd0,
      LEVEL_WARNING  = 2'd1,
      LEVEL_CRITICAL = 2'd2
   } level_type;

   typedef enum logic [1:0] {
      MOTOR_ON      = 2'd0,
      MOTOR_STANDBY = 2'd1,
      MOTOR_OFF     = 2'd2
   } motor_type;

endpackage

// ----- rtl/core/water_quality_index_scorer_top.sv -----
// Top level of the water quality index scorer: sub-scores, weighted total,
// clamp and classification in a six-stage pipeline.
// Depends on wqi_pkg for types, register indexes and division constants.
//
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is
//   low. The five readings on the req_ ports are captured at that edge.
//   The result appears on the rsp_ ports for exactly one cycle with
//   rsp_valid high. The pipeline takes one transaction per cycle, so start
//   may stay high for a continuous stream; the latency is set by the
//   register stages (input capture, curve scoring, weight multiply, sum,
//   divide by 1000, clamp and classify).
//   The receiver has no stall signal and must take each result when shown.
//   The five weights are written through the csr_ channel (index 0..4,
//   other indexes are ignored) and must only change while no transaction
//   is in flight.
//   Reset is synchronous and active high: it empties the pipeline, sets all
//   weights to 200; busy is high and csr_ready low up to the first edge after it.
module water_quality_index_scorer_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [10:0]                req_ph_reading,
   input  logic [14:0]                req_conductivity_reading,
   input  logic [13:0]                req_gas_ppm_reading,
   input  logic signed [14:0]         req_water_temp_reading,
   input  logic [13:0]                req_humidity_reading,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  wqi_pkg::weight_type        csr_data,
   output logic                       rsp_valid,
   output wqi_pkg::score_type         rsp_ph_score,
   output wqi_pkg::score_type         rsp_conductivity_score,
   output wqi_pkg::score_type         rsp_gas_score,
   output wqi_pkg::score_type         rsp_water_temp_score,
   output wqi_pkg::score_type         rsp_humidity_score,
   output wqi_pkg::score_type         rsp_quality_index,
   output wqi_pkg::level_type         rsp_quality_level,
   output wqi_pkg::motor_type         rsp_motor_action
);
   import wqi_pkg::*;

   logic accept;

   logic busy_ff;
   weight_type weight_ff [NUM_SENSORS];

   // Stage A: captured readings.
   logic               valid_a_ff;
   logic [10:0]        ph_ff;
   logic [14:0]        cond_ff;
   logic [13:0]        gas_ff;
   logic signed [14:0] temp_ff;
   logic [13:0]        hum_ff;

   // Stage B: sub-scores.
   logic      valid_b_ff;
   score_type score_b_in [NUM_SENSORS];
   score_type score_b_ff [NUM_SENSORS];

   // Stage C: weighted products.
   logic        valid_c_ff;
   logic [23:0] prod_c_ff  [NUM_SENSORS];
   score_type   score_c_ff [NUM_SENSORS];

   // Stage D: sum of products.
   logic        valid_d_ff;
   logic [25:0] sum_d_in;
   logic [25:0] sum_d_ff;
   score_type   score_d_ff [NUM_SENSORS];

   // Stage E: quotient of the sum by 1000.
   logic        valid_e_ff;
   logic [52:0] quot_prod;
   logic [15:0] quot_e_ff;
   score_type   score_e_ff [NUM_SENSORS];

   // Output stage.
   logic      rsp_valid_ff;
   score_type index_in;
   level_type level_in;
   motor_type motor_in;
   score_type score_o_ff [NUM_SENSORS];
   score_type index_ff;
   level_type level_ff;
   motor_type motor_ff;

   // Curve helpers.
   logic [10:0]        ph_dev;
   logic signed [15:0] temp_diff;
   logic [14:0]        temp_dev;
   logic [13:0]        hum_dev;
   logic [16:0]        cond_x;
   logic [33:0]        cond_div;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            weight_ff[i] <= WEIGHT_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WEIGHT_PH:         weight_ff[SENSOR_PH]         <= csr_data;
            CSR_WEIGHT_COND:       weight_ff[SENSOR_COND]       <= csr_data;
            CSR_WEIGHT_GAS:        weight_ff[SENSOR_GAS]        <= csr_data;
            CSR_WEIGHT_WATER_TEMP: weight_ff[SENSOR_WATER_TEMP] <= csr_data;
            CSR_WEIGHT_HUMIDITY:   weight_ff[SENSOR_HUMIDITY]   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         valid_d_ff   <= 1'b0;
         valid_e_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= accept;
         valid_b_ff   <= valid_a_ff;
         valid_c_ff   <= valid_b_ff;
         valid_d_ff   <= valid_c_ff;
         valid_e_ff   <= valid_d_ff;
         rsp_valid_ff <= valid_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ph_ff   <= req_ph_reading;
         cond_ff <= req_conductivity_reading;
         gas_ff  <= req_gas_ppm_reading;
         temp_ff <= req_water_temp_reading;
         hum_ff  <= req_humidity_reading;
      end
   end

   // Deviations from the ideal values of the symmetric curves.
   assign ph_dev    = (ph_ff >= 11'd700) ? (ph_ff - 11'd700) : (11'd700 - ph_ff);
   assign temp_diff = 16'(temp_ff) - 16'sd2500;
   assign temp_dev  = temp_diff[15] ? 15'(-temp_diff) : 15'(temp_diff);
   assign hum_dev   = (hum_ff >= 14'd5000) ? (hum_ff - 14'd5000) : (14'd5000 - hum_ff);

   // The 2.7-per-step conductivity segment is worked in tenths and then
   // divided by ten through a reciprocal multiply.
   assign cond_x   = 17'd97000 - (17'(cond_ff) - 17'd500) * 17'd27;
   assign cond_div = 34'(cond_x) * 34'(DIV10_RECIP);

   always_comb begin
      if (ph_dev <= 11'd50) begin
         score_b_in[SENSOR_PH] = SCORE_MAX;
      end else if (ph_dev <= 11'd150) begin
         score_b_in[SENSOR_PH] = 14'd10000 - (14'(ph_dev) - 14'd50) * 14'd30;
      end else if (ph_dev <= 11'd250) begin
         score_b_in[SENSOR_PH] = 14'd7000 - (14'(ph_dev) - 14'd150) * 14'd50;
      end else if (ph_dev < 11'd350) begin
         score_b_in[SENSOR_PH] = 14'd2000 - (14'(ph_dev) - 14'd250) * 14'd20;
      end else begin
         score_b_in[SENSOR_PH] = '0;
      end

      // The last conductivity tail is (10000 - 5k) / 10, which equals
      // 1000 - ceil(k / 2) with k the excess over 3000.
      if (cond_ff <= 15'd200) begin
         score_b_in[SENSOR_COND] = SCORE_MAX;
      end else if (cond_ff <= 15'd500) begin
         score_b_in[SENSOR_COND] = 14'd10000 - (14'(cond_ff) - 14'd200);
      end else if (cond_ff <= 15'd1500) begin
         score_b_in[SENSOR_COND] = cond_div[DIV10_SHIFT +: 14];
      end else if (cond_ff <= 15'd3000) begin
         score_b_in[SENSOR_COND] = 14'd7000 - ((14'(cond_ff) - 14'd1500) << 2);
      end else if (cond_ff < 15'd5000) begin
         score_b_in[SENSOR_COND] = 14'd1000 - ((14'(cond_ff) - 14'd2999) >> 1);
      end else begin
         score_b_in[SENSOR_COND] = '0;
      end

      if (gas_ff <= 14'd200) begin
         score_b_in[SENSOR_GAS] = SCORE_MAX;
      end else if (gas_ff <= 14'd500) begin
         score_b_in[SENSOR_GAS] = 14'd10000 - (gas_ff - 14'd200) * 14'd10;
      end else if (gas_ff <= 14'd1000) begin
         score_b_in[SENSOR_GAS] = 14'd7000 - (gas_ff - 14'd500) * 14'd10;
      end else if (gas_ff < 14'd2000) begin
         score_b_in[SENSOR_GAS] = 14'd2000 - ((gas_ff - 14'd1000) << 1);
      end else begin
         score_b_in[SENSOR_GAS] = '0;
      end

      if (temp_dev <= 15'd500) begin
         score_b_in[SENSOR_WATER_TEMP] = SCORE_MAX;
      end else if (temp_dev <= 15'd1000) begin
         score_b_in[SENSOR_WATER_TEMP] = 14'd10000 - (14'(temp_dev) - 14'd500) * 14'd10;
      end else if (temp_dev <= 15'd1500) begin
         score_b_in[SENSOR_WATER_TEMP] = 14'd5000 - (14'(temp_dev) - 14'd1000) * 14'd10;
      end else begin
         score_b_in[SENSOR_WATER_TEMP] = '0;
      end

      if (hum_dev <= 14'd2000) begin
         score_b_in[SENSOR_HUMIDITY] = SCORE_MAX;
      end else if (hum_dev <= 14'd3000) begin
         score_b_in[SENSOR_HUMIDITY] = 14'd10000 - (hum_dev - 14'd2000) * 14'd7;
      end else if (hum_dev <= 14'd4000) begin
         score_b_in[SENSOR_HUMIDITY] = 14'd3000 - (hum_dev - 14'd3000) * 14'd3;
      end else begin
         score_b_in[SENSOR_HUMIDITY] = '0;
      end
   end

   always_comb begin
      sum_d_in = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         sum_d_in = sum_d_in + 26'(prod_c_ff[i]);
      end
   end

   assign quot_prod = 53'(sum_d_ff) * 53'(DIV1000_RECIP);

   always_comb begin
      if (quot_e_ff > 16'(SCORE_MAX)) begin
         index_in = SCORE_MAX;
      end else begin
         index_in = quot_e_ff[13:0];
      end
      if (index_in >= GOOD_LIMIT) begin
         level_in = LEVEL_GOOD;
         motor_in = MOTOR_ON;
      end else if (index_in >= WARN_LIMIT) begin
         level_in = LEVEL_WARNING;
         motor_in = MOTOR_STANDBY;
      end else begin
         level_in = LEVEL_CRITICAL;
         motor_in = MOTOR_OFF;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
         score_b_ff[i] <= score_b_in[i];
         prod_c_ff[i]  <= 24'(score_b_ff[i]) * 24'(weight_ff[i]);
         score_c_ff[i] <= score_b_ff[i];
         score_d_ff[i] <= score_c_ff[i];
         score_e_ff[i] <= score_d_ff[i];
         score_o_ff[i] <= score_e_ff[i];
      end
      sum_d_ff  <= sum_d_in;
      quot_e_ff <= quot_prod[DIV1000_SHIFT +: 16];
      index_ff  <= index_in;
      level_ff  <= level_in;
      motor_ff  <= motor_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_ph_score           = score_o_ff[SENSOR_PH];
   assign rsp_conductivity_score = score_o_ff[SENSOR_COND];
   assign rsp_gas_score          = score_o_ff[SENSOR_GAS];
   assign rsp_water_temp_score   = score_o_ff[SENSOR_WATER_TEMP];
   assign rsp_humidity_score     = score_o_ff[SENSOR_HUMIDITY];
   assign rsp_quality_index      = index_ff;
   assign rsp_quality_level      = level_ff;
   assign rsp_motor_action       = motor_ff;

   // Every result traces back to an accepted transaction.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result without a matching transaction");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quality_index <= SCORE_MAX))
      else $error("quality index above the clamp limit");

   a_level_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_quality_level == LEVEL_GOOD) == (rsp_quality_index >= GOOD_LIMIT))
         && ((rsp_quality_level == LEVEL_CRITICAL) == (rsp_quality_index < WARN_LIMIT))))
      else $error("quality level does not match the index");

   a_motor_follows_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_quality_level == LEVEL_GOOD && rsp_motor_action == MOTOR_ON)
         || (rsp_quality_level == LEVEL_WARNING && rsp_motor_action == MOTOR_STANDBY)
         || (rsp_quality_level == LEVEL_CRITICAL && rsp_motor_action == MOTOR_OFF)))
      else $error("motor action does not follow the quality level");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the water quality index scorer.
// Predicts every result from the readings and the weights it has written, then
// checks each result field by field. Depends on wqi_pkg and the scorer RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wqi_pkg::*;

   localparam int IDLE_LIGHT     = 11;
   localparam int IDLE_HEAVY     = 87;
   localparam int IDLE_NONE      = 0;
   localparam int RESET_CYCLES   = 11;
   localparam int PIPE_DEPTH     = 6;
   localparam int GOOD_FLOOR     = 7000;
   localparam int WARNING_FLOOR  = 4000;
   localparam int INDEX_CEILING  = 10000;
   localparam logic [2:0] CSR_INDEX_TOP = 3'd7;

   typedef struct {
      logic [10:0]        ph;
      logic [14:0]        cond;
      logic [13:0]        gas;
      logic signed [14:0] temp;
      logic [13:0]        hum;
   } sensor_sample_type;

   typedef struct {
      score_type ph;
      score_type cond;
      score_type gas;
      score_type temp;
      score_type hum;
      score_type index;
      level_type level;
      motor_type motor;
   } quality_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [10:0]        req_ph_reading = '0;
   logic [14:0]        req_conductivity_reading = '0;
   logic [13:0]        req_gas_ppm_reading = '0;
   logic signed [14:0] req_water_temp_reading = '0;
   logic [13:0]        req_humidity_reading = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   weight_type         csr_data = '0;
   logic               rsp_valid;
   score_type          rsp_ph_score;
   score_type          rsp_conductivity_score;
   score_type          rsp_gas_score;
   score_type          rsp_water_temp_score;
   score_type          rsp_humidity_score;
   score_type          rsp_quality_index;
   level_type          rsp_quality_level;
   motor_type          rsp_motor_action;

   sensor_sample_type  pending_samples[$];
   quality_result_type quality_expected[$];
   weight_type         weight_shadow[NUM_SENSORS] = '{default: WEIGHT_RESET};
   int                 idle_pct = IDLE_LIGHT;
   int                 error_count = 0;

   water_quality_index_scorer_top i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .start                    (start),
      .busy                     (busy),
      .req_ph_reading           (req_ph_reading),
      .req_conductivity_reading (req_conductivity_reading),
      .req_gas_ppm_reading      (req_gas_ppm_reading),
      .req_water_temp_reading   (req_water_temp_reading),
      .req_humidity_reading     (req_humidity_reading),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .rsp_valid                (rsp_valid),
      .rsp_ph_score             (rsp_ph_score),
      .rsp_conductivity_score   (rsp_conductivity_score),
      .rsp_gas_score            (rsp_gas_score),
      .rsp_water_temp_score     (rsp_water_temp_score),
      .rsp_humidity_score       (rsp_humidity_score),
      .rsp_quality_index        (rsp_quality_index),
      .rsp_quality_level        (rsp_quality_level),
      .rsp_motor_action         (rsp_motor_action)
   );

   always #10 clock = ~clock;

   // Sensor curves, all in hundredths of a point.
   function automatic longint ph_points(longint ph);
      longint d;
      d = (ph < 700) ? 700 - ph : ph - 700;
      if (d <= 50) return 10000;
      if (d <= 150) return 10000 - (d - 50) * 30;
      if (d <= 250) return 7000 - (d - 150) * 50;
      return (d - 250) * 20 >= 2000 ? 0 : 2000 - (d - 250) * 20;
   endfunction

   // The middle segment has a slope of 2.7 per thousandth, so it is worked in
   // tenths and truncated.
   function automatic longint conductivity_points(longint ec);
      if (ec <= 200) return 10000;
      if (ec <= 500) return 10000 - (ec - 200);
      if (ec <= 1500) return (97000 - (ec - 500) * 27) / 10;
      if (ec <= 3000) return 7000 - (ec - 1500) * 4;
      return (ec - 3000) * 5 >= 10000 ? 0 : (10000 - (ec - 3000) * 5) / 10;
   endfunction

   function automatic longint gas_points(longint ppm);
      if (ppm <= 200) return 10000;
      if (ppm <= 500) return 10000 - (ppm - 200) * 10;
      if (ppm <= 1000) return 7000 - (ppm - 500) * 10;
      return (ppm - 1000) * 2 >= 2000 ? 0 : 2000 - (ppm - 1000) * 2;
   endfunction

   function automatic longint temperature_points(longint t);
      longint d;
      d = (t < 2500) ? 2500 - t : t - 2500;
      if (d <= 500) return 10000;
      if (d <= 1000) return 10000 - (d - 500) * 10;
      if (d <= 1500) return 5000 - (d - 1000) * 10;
      return 0;
   endfunction

   function automatic longint humidity_points(longint h);
      longint d;
      d = (h < 5000) ? 5000 - h : h - 5000;
      if (d <= 2000) return 10000;
      if (d <= 3000) return 10000 - (d - 2000) * 7;
      if (d <= 4000) return 3000 - (d - 3000) * 3;
      return 0;
   endfunction

   function automatic quality_result_type predict_quality(sensor_sample_type s);
      longint             pts[NUM_SENSORS];
      longint             total;
      quality_result_type r;
      pts[SENSOR_PH]         = ph_points(longint'(s.ph));
      pts[SENSOR_COND]       = conductivity_points(longint'(s.cond));
      pts[SENSOR_GAS]        = gas_points(longint'(s.gas));
      pts[SENSOR_WATER_TEMP] = temperature_points(longint'(s.temp));
      pts[SENSOR_HUMIDITY]   = humidity_points(longint'(s.hum));
      total = 0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         total += pts[i] * longint'(weight_shadow[i]);
      end
      total = total / 1000;
      if (total > INDEX_CEILING) begin
         total = INDEX_CEILING;
      end
      r.ph    = score_type'(pts[SENSOR_PH]);
      r.cond  = score_type'(pts[SENSOR_COND]);
      r.gas   = score_type'(pts[SENSOR_GAS]);
      r.temp  = score_type'(pts[SENSOR_WATER_TEMP]);
      r.hum   = score_type'(pts[SENSOR_HUMIDITY]);
      r.index = score_type'(total);
      if (total >= GOOD_FLOOR) begin
         r.level = LEVEL_GOOD;
         r.motor = MOTOR_ON;
      end else if (total >= WARNING_FLOOR) begin
         r.level = LEVEL_WARNING;
         r.motor = MOTOR_STANDBY;
      end else begin
         r.level = LEVEL_CRITICAL;
         r.motor = MOTOR_OFF;
      end
      return r;
   endfunction

   // Each field is drawn from its full port width, its documented range or the
   // part of its curve where the score moves.
   function automatic sensor_sample_type random_sample();
      sensor_sample_type s;
      case ($urandom_range(3))
         0: s.ph = 11'($urandom_range(2047));
         1: s.ph = 11'($urandom_range(1400));
         default: s.ph = 11'($urandom_range(1100, 300));
      endcase
      case ($urandom_range(3))
         0: s.cond = 15'($urandom_range(32767));
         1: s.cond = 15'($urandom_range(20000));
         default: s.cond = 15'($urandom_range(5500));
      endcase
      case ($urandom_range(3))
         0: s.gas = 14'($urandom_range(16383));
         1: s.gas = 14'($urandom_range(10000));
         default: s.gas = 14'($urandom_range(2100));
      endcase
      case ($urandom_range(3))
         0: s.temp = 15'($urandom_range(32767));
         1: s.temp = 15'(int'($urandom_range(16500)) - 4000);
         default: s.temp = 15'($urandom_range(4500, 500));
      endcase
      case ($urandom_range(3))
         0: s.hum = 14'($urandom_range(16383));
         default: s.hum = 14'($urandom_range(10000));
      endcase
      return s;
   endfunction

   function automatic void add_sample(int ph, int cond, int gas, int temp, int hum);
      sensor_sample_type s;
      s.ph   = 11'(ph);
      s.cond = 15'(cond);
      s.gas  = 14'(gas);
      s.temp = 15'(temp);
      s.hum  = 14'(hum);
      pending_samples.push_back(s);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Driver: a transaction is taken when start is high and busy is low.
   always @(posedge clock) begin : driver
      sensor_sample_type s;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            s.ph   = req_ph_reading;
            s.cond = req_conductivity_reading;
            s.gas  = req_gas_ppm_reading;
            s.temp = req_water_temp_reading;
            s.hum  = req_humidity_reading;
            quality_expected.push_back(predict_quality(s));
         end
         if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
            s = pending_samples.pop_front();
            req_ph_reading           <= s.ph;
            req_conductivity_reading <= s.cond;
            req_gas_ppm_reading      <= s.gas;
            req_water_temp_reading   <= s.temp;
            req_humidity_reading     <= s.hum;
            start                    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      quality_result_type want;
      if (!reset && rsp_valid) begin
         if (quality_expected.size() == 0) begin
            error_count++;
            $display("%0t: result expected none, actual index %0d", $time,
                     rsp_quality_index);
         end else begin
            want = quality_expected.pop_front();
            check_field("ph_score", want.ph, rsp_ph_score);
            check_field("conductivity_score", want.cond, rsp_conductivity_score);
            check_field("gas_score", want.gas, rsp_gas_score);
            check_field("water_temp_score", want.temp, rsp_water_temp_score);
            check_field("humidity_score", want.hum, rsp_humidity_score);
            check_field("quality_index", want.index, rsp_quality_index);
            check_field("quality_level", want.level, rsp_quality_level);
            check_field("motor_action", want.motor, rsp_motor_action);
         end
      end
   end

   task automatic write_weight(logic [2:0] idx, weight_type value);
      @(posedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx <= CSR_WEIGHT_HUMIDITY) begin
         weight_shadow[idx] = value;
      end
   endtask

   task automatic set_weights(weight_type w_ph, weight_type w_cond, weight_type w_gas,
                              weight_type w_temp, weight_type w_hum);
      write_weight(CSR_WEIGHT_PH, w_ph);
      write_weight(CSR_WEIGHT_COND, w_cond);
      write_weight(CSR_WEIGHT_GAS, w_gas);
      write_weight(CSR_WEIGHT_WATER_TEMP, w_temp);
      write_weight(CSR_WEIGHT_HUMIDITY, w_hum);
   endtask

   // The sender holds off until every outstanding transaction has returned.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || start || quality_expected.size() != 0);
   endtask

   initial begin : stimulus
      int count;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed set, with the reset weights of 200 each.
      add_sample(700, 0, 0, 2500, 5000);
      add_sample(0, 32767, 16383, -16384, 16383);
      add_sample(2047, 20000, 10000, 16383, 0);
      add_sample(1400, 5001, 2001, 12500, 10000);
      add_sample(650, 200, 200, 2000, 3000);
      add_sample(750, 201, 201, 3000, 7000);
      add_sample(550, 500, 500, 1500, 2000);
      add_sample(849, 501, 501, 3501, 8000);
      add_sample(450, 1500, 1000, 1000, 1000);
      add_sample(950, 1501, 1001, 4000, 9000);
      add_sample(350, 3000, 2000, 999, 999);
      add_sample(351, 3001, 1999, 4001, 9001);
      add_sample(1051, 5000, 1500, -4000, 10000);
      add_sample(1049, 4999, 800, 3499, 1500);
      // Totals on both sides of the good and warning thresholds.
      add_sample(700, 0, 0, 1500, 0);
      add_sample(700, 205, 0, 1500, 0);
      add_sample(700, 0, 16383, -16384, 0);
      add_sample(700, 205, 16383, -16384, 0);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               set_weights(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
               // Writes to unused indexes must leave the weights alone.
               for (int i = CSR_WEIGHT_HUMIDITY + 1; i <= CSR_INDEX_TOP; i++) begin
                  write_weight(i[2:0], weight_type'($urandom_range(1023)));
               end
               idle_pct = IDLE_LIGHT;
               count = 120;
            end
            1: begin
               set_weights('0, '0, '0, '0, '0);
               idle_pct = IDLE_LIGHT;
               count = 60;
            end
            2: begin
               set_weights(weight_type'($urandom_range(1023)),
                           weight_type'($urandom_range(1023)),
                           weight_type'($urandom_range(1023)),
                           weight_type'($urandom_range(1023)),
                           weight_type'($urandom_range(1023)));
               idle_pct = IDLE_HEAVY;
               count = 130;
            end
            3: begin
               set_weights(10'd1000, 10'd0, 10'd1000, 10'd0, 10'd1000);
               idle_pct = IDLE_HEAVY;
               count = 120;
            end
            4: begin
               set_weights(WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET,
                           WEIGHT_RESET);
               idle_pct = IDLE_NONE;
               count = 120;
            end
            default: begin
               set_weights(weight_type'($urandom_range(400)),
                           weight_type'($urandom_range(400)),
                           weight_type'($urandom_range(400)),
                           weight_type'($urandom_range(400)),
                           weight_type'($urandom_range(400)));
               idle_pct = IDLE_NONE;
               count = 200;
            end
         endcase
         @(negedge clock);
         repeat (count) pending_samples.push_back(random_sample());
         wait_drained();
      end

      // Any stray result still in the pipeline shows up within its depth.
      repeat (2 * PIPE_DEPTH) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
